FILE: hw/rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Types, command codes and small calendar helper functions shared by the
// calendar clock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [3:0]  MONTH_MAX = 4'd11;
  localparam logic [2:0]  WDAY_MAX  = 3'd6;
  localparam logic [13:0] YEAR_MIN  = 14'd1;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [13:0] YEAR_RST  = 14'd2023;

  // floor(y / 100) as (y * 5243) >> 19, exact for y below 10000
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;

  // keeps the weekday sum non-negative against the -2c term (7 * 29)
  localparam logic [9:0]  ZELLER_BIAS = 10'd203;

  typedef struct packed {
    logic        cmd;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } cal_in_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        new_day;
  } cal_out_t;

  // clamped load fields plus century split of the weekday year
  typedef struct packed {
    logic        cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  cent;
    logic [6:0]  yoc;
  } cal_prep_t;

  function automatic logic [6:0] div100(input logic [13:0] y);
    logic [26:0] prod;
    prod = 27'(y) * 27'(DIV100_MUL);
    return prod[DIV100_SH +: 7];
  endfunction

  function automatic logic [6:0] rem100(input logic [13:0] y, input logic [6:0] q);
    logic [13:0] diff;
    diff = y - 14'(q) * 14'd100;
    return diff[6:0];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [6:0] q;
    logic [6:0] r;
    q = div100(y);
    r = rem100(y, q);
    return ((y[1:0] == 2'd0) && (r != 7'd0)) || ((r == 7'd0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [5:0] month_days(input logic [3:0] m);
    logic [5:0] len;
    unique case (m)
      4'd1:                      len = 6'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 6'd30;
      default:                   len = 6'd31;
    endcase
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) with january and february as months 13 and 14
  function automatic logic [5:0] zeller_month(input logic [3:0] m);
    logic [5:0] t;
    unique case (m)
      4'd0:    t = 6'd36;
      4'd1:    t = 6'd39;
      4'd2:    t = 6'd10;
      4'd3:    t = 6'd13;
      4'd4:    t = 6'd15;
      4'd5:    t = 6'd18;
      4'd6:    t = 6'd20;
      4'd7:    t = 6'd23;
      4'd8:    t = 6'd26;
      4'd9:    t = 6'd28;
      4'd10:   t = 6'd31;
      default: t = 6'd33;
    endcase
    return t;
  endfunction

  // octal digit folding, since 8 is 1 modulo 7
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cal_load_prep.sv
// ----------------------------------------------------------------------------
// cal_load_prep
// Input stage: registers the item with its load fields clamped and the
// weekday year split into century and year of century.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_load_prep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cal_pkg::cal_in_t  in_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output cal_pkg::cal_prep_t     dn_data
);

  logic               vld_r;
  cal_pkg::cal_prep_t data_r;
  cal_pkg::cal_prep_t data_nxt;
  logic [13:0]        zy;
  logic [6:0]         zq;

  assign in_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.cmd = in_data.cmd;
    if (in_data.set_year < cal_pkg::YEAR_MIN) begin
      data_nxt.year = cal_pkg::YEAR_MIN;
    end else if (in_data.set_year > cal_pkg::YEAR_MAX) begin
      data_nxt.year = cal_pkg::YEAR_MAX;
    end else begin
      data_nxt.year = in_data.set_year;
    end
    data_nxt.month  = (in_data.set_month > cal_pkg::MONTH_MAX) ?
                      cal_pkg::MONTH_MAX : in_data.set_month;
    data_nxt.day    = (in_data.set_day == 5'd0) ? 5'd1 : in_data.set_day;
    data_nxt.hour   = (in_data.set_hour > cal_pkg::HOUR_MAX) ?
                      cal_pkg::HOUR_MAX : in_data.set_hour;
    data_nxt.minute = (in_data.set_minute > cal_pkg::MIN_MAX) ?
                      cal_pkg::MIN_MAX : in_data.set_minute;
    data_nxt.second = (in_data.set_second > cal_pkg::SEC_MAX) ?
                      cal_pkg::SEC_MAX : in_data.set_second;
    // january and february count toward the previous year
    zy = (data_nxt.month <= 4'd1) ? data_nxt.year - 14'd1 : data_nxt.year;
    zq = cal_pkg::div100(zy);
    data_nxt.cent = zq;
    data_nxt.yoc  = cal_pkg::rem100(zy, zq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cal_time_core.sv
// ----------------------------------------------------------------------------
// cal_time_core
// Calendar state and result register: applies a tick or a load to the
// time and date registers and presents the new values as the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_time_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire cal_pkg::cal_prep_t up_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cal_pkg::cal_out_t       out_data
);

  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r,  year_nxt;
  logic [2:0]  wday_r,  wday_nxt;
  logic        rolled;

  logic              out_valid_r;
  cal_pkg::cal_out_t out_data_r;

  logic        take;
  logic [5:0]  day_inc;
  logic [5:0]  len;
  logic [9:0]  zsum;

  assign up_ready  = !out_valid_r || out_ready;
  assign take      = up_valid && up_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    wday_nxt  = wday_r;
    rolled    = 1'b0;

    day_inc = 6'(day_r) + 6'd1;
    len     = cal_pkg::month_days(month_r) +
              6'((month_r == 4'd1) && cal_pkg::is_leap(year_r));

    zsum = 10'(up_data.cent[6:2]) + cal_pkg::ZELLER_BIAS - 10'({up_data.cent, 1'b0}) +
           10'(up_data.yoc) + 10'(up_data.yoc[6:2]) +
           10'(cal_pkg::zeller_month(up_data.month)) + 10'(up_data.day) - 10'd1;

    if (up_data.cmd == cal_pkg::CMD_LOAD) begin
      sec_nxt   = up_data.second;
      min_nxt   = up_data.minute;
      hour_nxt  = up_data.hour;
      day_nxt   = up_data.day;
      month_nxt = up_data.month;
      year_nxt  = up_data.year;
      wday_nxt  = cal_pkg::mod7(zsum[8:0]);
    end else if (sec_r < cal_pkg::SEC_MAX) begin
      sec_nxt = sec_r + 6'd1;
    end else begin
      sec_nxt = 6'd0;
      if (min_r < cal_pkg::MIN_MAX) begin
        min_nxt = min_r + 6'd1;
      end else begin
        min_nxt = 6'd0;
        if (hour_r < cal_pkg::HOUR_MAX) begin
          hour_nxt = hour_r + 5'd1;
        end else begin
          hour_nxt = 5'd0;
          rolled   = 1'b1;
          wday_nxt = (wday_r >= cal_pkg::WDAY_MAX) ? 3'd0 : wday_r + 3'd1;
          // a loaded day past the month's end also rolls to the next month
          if (day_inc > len) begin
            day_nxt = 5'd1;
            if (month_r >= cal_pkg::MONTH_MAX) begin
              month_nxt = 4'd0;
              year_nxt  = (year_r >= cal_pkg::YEAR_MAX) ? cal_pkg::YEAR_MIN :
                          year_r + 14'd1;
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            day_nxt = day_inc[4:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= 6'd0;
      min_r   <= 6'd0;
      hour_r  <= 5'd0;
      day_r   <= 5'd1;
      month_r <= 4'd0;
      year_r  <= cal_pkg::YEAR_RST;
      wday_r  <= 3'd0;
    end else if (take) begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      wday_r  <= wday_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.second  <= sec_nxt;
      out_data_r.minute  <= min_nxt;
      out_data_r.hour    <= hour_nxt;
      out_data_r.day     <= day_nxt;
      out_data_r.month   <= month_nxt;
      out_data_r.year    <= year_nxt;
      out_data_r.weekday <= wday_nxt;
      out_data_r.new_day <= rolled;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/calendar_clock_with_weekday_top.sv
// An accepted item is held in the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls; both registers
// take a new item whenever the stage after them moves on.
// Reset: time 00:00:00, 1 January 2023, Sunday; both stages empty.
// ----------------------------------------------------------------------------
// calendar_clock_with_weekday_top
// Calendar clock with weekday: one-second ticks and date/time loads, one
// result item per input item.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_with_weekday_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cal_pkg::cal_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cal_pkg::cal_out_t      out_data
);

  logic               prep_valid;
  logic               prep_ready;
  cal_pkg::cal_prep_t prep_data;

  cal_load_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep_data)
  );

  cal_time_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (prep_valid),
    .up_ready  (prep_ready),
    .up_data   (prep_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cal_checker.sv
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks on the calendar clock result channel, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire cal_pkg::cal_out_t out_data
);

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // every reported time and date is in range, also after clamped loads
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.second <= 6'd59) && (out_data.minute <= 6'd59) &&
                  (out_data.hour <= 5'd23) && (out_data.day != 5'd0) &&
                  (out_data.month <= 4'd11) && (out_data.weekday <= 3'd6) &&
                  (out_data.year != 14'd0) && (out_data.year <= 14'd9999))
    else $error("result field out of range");

  // a day rollover lands on midnight
  a_new_day_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_day |->
      (out_data.second == 6'd0) && (out_data.minute == 6'd0) && (out_data.hour == 5'd0))
    else $error("new day flagged away from midnight");

  // nothing comes out of an empty block right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

endmodule

bind calendar_clock_with_weekday_top cal_checker u_cal_checker (.*);

`default_nettype wire
